// File: rtl/adfea_line_parser_macros.svh
// assertion macros for the line parser
`ifndef ADFEA_LINE_PARSER_MACROS_SVH
`define ADFEA_LINE_PARSER_MACROS_SVH

// same-cycle implication, checked outside reset
`define ADF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define ADF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/adfea_pkg.sv
// shared types and constants of the line parser
package adfea_pkg;

  // character codes
  localparam logic [7:0] CH_EOL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // label codes
  localparam logic [1:0] LABEL_NONE = 2'b00;
  localparam logic [1:0] LABEL_POS  = 2'b01;
  localparam logic [1:0] LABEL_NEG  = 2'b11;

  // register map
  localparam int unsigned PADDR_W = 3;
  localparam logic [0:0] REG_IGNORE_GROUP = 1'b0;

  // accumulator widths and limits
  localparam int unsigned ACC_W = 64;
  localparam int unsigned SUM_W = ACC_W + 4;
  localparam logic [SUM_W-1:0] GROUP_MAG_LIMIT = 68'h0_0000_0000_8000_0000;
  localparam logic [ACC_W-1:0] GROUP_POS_MAX   = 64'h0000_0000_7FFF_FFFF;

  // stream widths
  localparam int unsigned TDATA_W = 104;

  // token position within the line
  typedef enum logic [2:0] {
    PH_SKIP0 = 3'd0,
    PH_SKIP1 = 3'd1,
    PH_LABEL = 3'd2,
    PH_FEAT  = 3'd3,
    PH_GROUP = 3'd4
  } phase_e;

  // one result word
  typedef struct packed {
    logic        is_feature;
    logic [63:0] feat_id;
    logic [31:0] grp_id;
    logic        new_group;
    logic [1:0]  label;
    logic        last_of_line;
    logic        status;
  } res_t;

  // results produced by one character, first in r0
  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } push_t;

  // modulo-3 pointer step
  function automatic logic [1:0] inc3(input logic [1:0] p);
    logic [1:0] r;
    r = (p == 2'd2) ? 2'd0 : p + 2'd1;
    return r;
  endfunction

endpackage

// File: rtl/adfea_parse.sv
// per-character token parser with line state
module adfea_parse (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic [7:0]          char_i,
  input  logic                ignore_i,
  output adfea_pkg::push_t    push_o
);

  adfea_pkg::phase_e phase_q, phase_d;
  logic              in_tok_q, in_tok_d;
  logic [63:0]       acc_q, acc_d;
  logic              neg_q, neg_d;
  logic              dig_q, dig_d;
  logic [63:0]       pend_q, pend_d;
  logic              pg_valid_q, pg_valid_d;
  logic [31:0]       pg_val_q, pg_val_d;
  logic [1:0]        label_q, label_d;
  logic              err_q, err_d;

  // token close results
  logic              num;
  logic              cl_err;
  adfea_pkg::phase_e cl_phase;
  logic [1:0]        cl_label;
  logic [63:0]       cl_pend;
  logic              cl_emit;
  logic [31:0]       cl_grp;
  logic              cl_ng;
  adfea_pkg::res_t   cl_res;

  // digit accumulate
  logic [3:0]        digit;
  logic [67:0]       sum;
  logic              ovf;
  logic              is_digit;

  adfea_pkg::res_t   eol_res;

  assign num = (phase_q == adfea_pkg::PH_LABEL) || (phase_q == adfea_pkg::PH_FEAT) ||
               ((phase_q == adfea_pkg::PH_GROUP) && !ignore_i);

  // what closing the current token would do
  always_comb begin
    cl_err   = 1'b0;
    cl_phase = phase_q;
    cl_label = label_q;
    cl_pend  = pend_q;
    cl_emit  = 1'b0;
    cl_grp   = ignore_i ? 32'd0 : (neg_q ? 32'd0 - acc_q[31:0] : acc_q[31:0]);
    cl_ng    = !pg_valid_q || (pg_val_q != cl_grp);
    if (num && !dig_q) begin
      cl_err = 1'b1;
    end else if (num && phase_q != adfea_pkg::PH_FEAT && !neg_q &&
                 acc_q > adfea_pkg::GROUP_POS_MAX) begin
      cl_err = 1'b1;
    end else begin
      unique case (phase_q)
        adfea_pkg::PH_SKIP0: cl_phase = adfea_pkg::PH_SKIP1;
        adfea_pkg::PH_SKIP1: cl_phase = adfea_pkg::PH_LABEL;
        adfea_pkg::PH_LABEL: begin
          cl_label = (!neg_q && acc_q != 64'd0) ? adfea_pkg::LABEL_POS : adfea_pkg::LABEL_NEG;
          cl_phase = adfea_pkg::PH_FEAT;
        end
        adfea_pkg::PH_FEAT: begin
          cl_pend  = acc_q;
          cl_phase = adfea_pkg::PH_GROUP;
        end
        adfea_pkg::PH_GROUP: begin
          cl_emit  = 1'b1;
          cl_phase = adfea_pkg::PH_FEAT;
        end
        default: cl_phase = phase_q;
      endcase
    end
    cl_res.is_feature   = 1'b1;
    cl_res.feat_id      = pend_q;
    cl_res.grp_id       = cl_grp;
    cl_res.new_group    = cl_ng;
    cl_res.label        = label_q;
    cl_res.last_of_line = 1'b0;
    cl_res.status       = 1'b0;
  end

  // decimal step: acc * 10 + digit, checked against the token's limit
  assign digit    = char_i[3:0] - adfea_pkg::CH_ZERO[3:0];
  assign sum      = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {64'd0, digit};
  assign ovf      = (phase_q == adfea_pkg::PH_FEAT) ? (sum[67:64] != 4'd0)
                                                    : (sum > adfea_pkg::GROUP_MAG_LIMIT);
  assign is_digit = (char_i >= adfea_pkg::CH_ZERO) && (char_i <= adfea_pkg::CH_NINE);

  // next state and results
  always_comb begin
    phase_d    = phase_q;
    in_tok_d   = in_tok_q;
    acc_d      = acc_q;
    neg_d      = neg_q;
    dig_d      = dig_q;
    pend_d     = pend_q;
    pg_valid_d = pg_valid_q;
    pg_val_d   = pg_val_q;
    label_d    = label_q;
    err_d      = err_q;
    push_o.cnt = 2'd0;
    push_o.r0  = cl_res;
    push_o.r1  = cl_res;

    eol_res.is_feature   = 1'b0;
    eol_res.feat_id      = 64'd0;
    eol_res.grp_id       = 32'd0;
    eol_res.new_group    = 1'b0;
    eol_res.label        = label_q;
    eol_res.last_of_line = 1'b1;
    eol_res.status       = err_q;

    if (en_i) begin
      if (char_i == adfea_pkg::CH_EOL) begin
        if (!err_q && in_tok_q) begin
          eol_res.label  = cl_label;
          eol_res.status = cl_err;
        end
        if (!err_q && in_tok_q && !cl_err && cl_emit) begin
          push_o.cnt = 2'd2;
          push_o.r1  = eol_res;
        end else begin
          push_o.cnt = 2'd1;
          push_o.r0  = eol_res;
        end
        // back to the start of a line
        phase_d    = adfea_pkg::PH_SKIP0;
        in_tok_d   = 1'b0;
        acc_d      = 64'd0;
        neg_d      = 1'b0;
        dig_d      = 1'b0;
        pend_d     = 64'd0;
        pg_valid_d = 1'b0;
        pg_val_d   = 32'd0;
        label_d    = adfea_pkg::LABEL_NONE;
        err_d      = 1'b0;
      end else if (err_q) begin
        // skip the rest of a bad line
      end else if (char_i == adfea_pkg::CH_SPACE || char_i == adfea_pkg::CH_COLON) begin
        if (in_tok_q) begin
          in_tok_d = 1'b0;
          acc_d    = 64'd0;
          neg_d    = 1'b0;
          dig_d    = 1'b0;
          if (cl_err) begin
            err_d = 1'b1;
          end else begin
            phase_d = cl_phase;
            label_d = cl_label;
            pend_d  = cl_pend;
            if (cl_emit) begin
              push_o.cnt = 2'd1;
              pg_valid_d = 1'b1;
              pg_val_d   = cl_grp;
            end
          end
        end
      end else begin
        in_tok_d = 1'b1;
        if (num) begin
          if (is_digit) begin
            if (ovf) begin
              err_d = 1'b1;
            end else begin
              acc_d = sum[63:0];
              dig_d = 1'b1;
            end
          end else if (!in_tok_q && char_i == adfea_pkg::CH_PLUS) begin
            // leading plus
          end else if (!in_tok_q && char_i == adfea_pkg::CH_MINUS &&
                       phase_q != adfea_pkg::PH_FEAT) begin
            neg_d = 1'b1;
          end else begin
            err_d = 1'b1;
          end
        end
      end
    end
  end

  // line state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= adfea_pkg::PH_SKIP0;
      in_tok_q   <= 1'b0;
      acc_q      <= 64'd0;
      neg_q      <= 1'b0;
      dig_q      <= 1'b0;
      pend_q     <= 64'd0;
      pg_valid_q <= 1'b0;
      pg_val_q   <= 32'd0;
      label_q    <= adfea_pkg::LABEL_NONE;
      err_q      <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      in_tok_q   <= in_tok_d;
      acc_q      <= acc_d;
      neg_q      <= neg_d;
      dig_q      <= dig_d;
      pend_q     <= pend_d;
      pg_valid_q <= pg_valid_d;
      pg_val_q   <= pg_val_d;
      label_q    <= label_d;
      err_q      <= err_d;
    end
  end

endmodule

// File: rtl/adfea_rfifo.sv
// three-entry result queue taking up to two words per cycle
module adfea_rfifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  adfea_pkg::push_t push_i,
  input  logic             pop_i,
  output logic             room_o,
  output logic             valid_o,
  output adfea_pkg::res_t  head_o
);

  adfea_pkg::res_t mem_q [3];
  logic [1:0]      wp_q, wp_d;
  logic [1:0]      rp_q, rp_d;
  logic [1:0]      cnt_q, cnt_d;
  logic            pop;

  assign valid_o = (cnt_q != 2'd0);
  assign room_o  = (cnt_q <= 2'd1);
  assign head_o  = mem_q[rp_q];
  assign pop     = pop_i && valid_o;

  // pointers and fill level
  always_comb begin
    wp_d  = wp_q;
    rp_d  = pop ? adfea_pkg::inc3(rp_q) : rp_q;
    cnt_d = cnt_q + push_i.cnt - {1'b0, pop};
    unique case (push_i.cnt)
      2'd1:    wp_d = adfea_pkg::inc3(wp_q);
      2'd2:    wp_d = adfea_pkg::inc3(adfea_pkg::inc3(wp_q));
      default: wp_d = wp_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 2'd0;
      rp_q  <= 2'd0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wp_q] <= push_i.r0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[adfea_pkg::inc3(wp_q)] <= push_i.r1;
    end
  end

endmodule

// File: rtl/adfea_line_parser.sv
// top level of the character-serial line parser
//
//  channel | dir | payload
//  s_axis  | in  | tdata[7:0] char_code
//  m_axis  | out | tdata feat_id..status, tuser is_feature, tlast last_of_line
//  apb     | in  | register 0 at byte address 0: ignore_group
//
// one character per cycle while the result queue has room: input register, one pass of parse logic, result queue
// the decimal step (acc * 10 + digit and limit check) is the longest path
// a character giving two words writes both into the result queue, and both go out on the master side
// the input side stalls only when the three-word result queue holds two or more words
// reset clears all line state and the register; no clearing pass
`include "adfea_line_parser_macros.svh"

module adfea_line_parser (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // character stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,   // [7:0] char_code
  // result stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [63:0] feat_id, [95:64] grp_id, [96] new_group, [98:97] label,
  // [99] status, [103:100] zero
  output logic [adfea_pkg::TDATA_W-1:0]   m_axis_tdata,
  output logic                            m_axis_tuser,   // [0] is_feature
  output logic                            m_axis_tlast,
  // configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [adfea_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  logic             ignore_q;
  logic             in_valid_q;
  logic [7:0]       char_q;
  logic             fire;
  logic             room;
  logic             cfg_hit;
  adfea_pkg::push_t push;
  adfea_pkg::res_t  head;

  // register port
  assign pready  = 1'b1;
  assign cfg_hit = (paddr[2:2] == adfea_pkg::REG_IGNORE_GROUP);
  assign prdata  = cfg_hit ? {31'd0, ignore_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ignore_q <= 1'b0;
    end else if (psel && penable && pwrite && cfg_hit) begin
      ignore_q <= pwdata[0];
    end
  end

  // input register
  assign fire          = in_valid_q && room;
  assign s_axis_tready = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      char_q <= s_axis_tdata;
    end
  end

  adfea_parse u_parse (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (fire),
    .char_i   (char_q),
    .ignore_i (ignore_q),
    .push_o   (push)
  );

  adfea_rfifo u_rfifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (m_axis_tready),
    .room_o  (room),
    .valid_o (m_axis_tvalid),
    .head_o  (head)
  );

  // result word packing
  assign m_axis_tdata = {4'd0, head.status, head.label, head.new_group,
                         head.grp_id, head.feat_id};
  assign m_axis_tuser = head.is_feature;
  assign m_axis_tlast = head.last_of_line;

  // checks
  `ADF_ASSERT_NOW(a_last_not_feature, m_axis_tvalid && m_axis_tlast, !m_axis_tuser, "end-of-line word flagged as feature")
  `ADF_ASSERT_NOW(a_feature_ok_status, m_axis_tvalid && m_axis_tuser, !m_axis_tdata[99] && !m_axis_tlast, "feature word carries status or last")
  `ADF_ASSERT_NOW(a_no_overwrite, s_axis_tvalid && s_axis_tready && in_valid_q, fire, "input register overwritten before parse")
  `ADF_ASSERT_NEXT(a_accept_loads, s_axis_tvalid && s_axis_tready, in_valid_q, "accepted character not held")

endmodule

// File: bench/adfea_line_parser_tb.sv
// self-checking bench for the line parser: directed lines, random lines, stalls, register writes
`timescale 1ns / 1ps

module adfea_line_parser_tb;

  localparam int unsigned SETTLE_CYCLES   = 8;
  localparam int unsigned HOLD_CYCLES     = 400;
  localparam int unsigned WATCHDOG_LIMIT  = 3000;
  localparam int unsigned CHARS_PER_PHASE = 320;

  // line parse predictor and store of words still due
  class line_parse_scoreboard;
    logic              ignore_grp;
    adfea_pkg::phase_e tok_phase;
    logic              in_tok;
    logic [63:0]       acc;
    logic              neg;
    logic              dig_seen;
    logic [63:0]       pend_feat;
    logic              have_group;
    logic [31:0]       last_group;
    logic [1:0]        line_lbl;
    logic              line_err;
    adfea_pkg::res_t   words_due[$];
    int unsigned chars, lines, bad_lines, feature_words, eol_words, reg_writes, fails;

    function void clear_line();
      tok_phase  = adfea_pkg::PH_SKIP0;
      in_tok     = 1'b0;
      acc        = '0;
      neg        = 1'b0;
      dig_seen   = 1'b0;
      pend_feat  = '0;
      have_group = 1'b0;
      last_group = '0;
      line_lbl   = adfea_pkg::LABEL_NONE;
      line_err   = 1'b0;
    endfunction

    function new();
      ignore_grp = 1'b0;
      clear_line();
    endfunction

    function logic parses_num();
      return tok_phase == adfea_pkg::PH_LABEL || tok_phase == adfea_pkg::PH_FEAT ||
             (tok_phase == adfea_pkg::PH_GROUP && !ignore_grp);
    endfunction

    function void push_word(logic isf, logic [63:0] fid, logic [31:0] gid, logic ng,
                            logic last, logic st);
      adfea_pkg::res_t w;
      w.is_feature   = isf;
      w.feat_id      = fid;
      w.grp_id       = gid;
      w.new_group    = ng;
      w.label        = line_lbl;
      w.last_of_line = last;
      w.status       = st;
      words_due.push_back(w);
    endfunction

    // end of a token: label, feature or group takes effect here
    function void close_token();
      logic        num;
      logic [31:0] g;
      num = parses_num();
      if (num && !dig_seen) begin
        line_err = 1'b1;
      end else if (num && tok_phase != adfea_pkg::PH_FEAT && !neg &&
                   acc > adfea_pkg::GROUP_POS_MAX) begin
        line_err = 1'b1;
      end else if (tok_phase < adfea_pkg::PH_LABEL) begin
        tok_phase = adfea_pkg::phase_e'(tok_phase + 1);
      end else if (tok_phase == adfea_pkg::PH_LABEL) begin
        line_lbl  = (!neg && acc != 0) ? adfea_pkg::LABEL_POS : adfea_pkg::LABEL_NEG;
        tok_phase = adfea_pkg::PH_FEAT;
      end else if (tok_phase == adfea_pkg::PH_FEAT) begin
        pend_feat = acc;
        tok_phase = adfea_pkg::PH_GROUP;
      end else begin
        g = ignore_grp ? 32'd0 : acc[31:0];
        if (!ignore_grp && neg) g = -g;
        push_word(1'b1, pend_feat, g, !have_group || last_group != g, 1'b0, 1'b0);
        have_group = 1'b1;
        last_group = g;
        tok_phase  = adfea_pkg::PH_FEAT;
      end
      in_tok   = 1'b0;
      acc      = '0;
      neg      = 1'b0;
      dig_seen = 1'b0;
    endfunction

    // one accepted character
    function void take_char(logic [7:0] c);
      logic        first;
      logic [63:0] d;
      logic [63:0] lim;
      chars++;
      if (c == adfea_pkg::CH_EOL) begin
        if (!line_err && in_tok) close_token();
        push_word(1'b0, '0, '0, 1'b0, 1'b1, line_err);
        lines++;
        if (line_err) bad_lines++;
        clear_line();
        return;
      end
      if (line_err) return;
      if (c == adfea_pkg::CH_SPACE || c == adfea_pkg::CH_COLON) begin
        if (in_tok) close_token();
        return;
      end
      first  = !in_tok;
      in_tok = 1'b1;
      if (!parses_num()) return;
      if (c >= adfea_pkg::CH_ZERO && c <= adfea_pkg::CH_NINE) begin
        d   = 64'(c - adfea_pkg::CH_ZERO);
        lim = (tok_phase == adfea_pkg::PH_FEAT) ? '1 : 64'h8000_0000;
        if (acc > (lim - d) / 64'd10) begin
          line_err = 1'b1;
        end else begin
          acc      = acc * 64'd10 + d;
          dig_seen = 1'b1;
        end
      end else if (first && c == adfea_pkg::CH_PLUS) begin
        // leading plus is allowed everywhere
      end else if (first && c == adfea_pkg::CH_MINUS && tok_phase != adfea_pkg::PH_FEAT) begin
        neg = 1'b1;
      end else begin
        line_err = 1'b1;
      end
    endfunction

    function void cmp(string field, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, got %0h", field, want, got);
        fails++;
      end
    endfunction

    // one accepted result word against the oldest one due
    function void check_word(adfea_pkg::res_t got);
      adfea_pkg::res_t w;
      if (words_due.size() == 0) begin
        $error("result word with none due: feature %0h group %0h last %0b",
               got.feat_id, got.grp_id, got.last_of_line);
        fails++;
        return;
      end
      w = words_due.pop_front();
      if (w.last_of_line) eol_words++;
      else feature_words++;
      cmp("is_feature",   64'(w.is_feature),   64'(got.is_feature));
      cmp("feat_id",      w.feat_id,           got.feat_id);
      cmp("grp_id",       64'(w.grp_id),       64'(got.grp_id));
      cmp("new_group",    64'(w.new_group),    64'(got.new_group));
      cmp("label",        64'(w.label),        64'(got.label));
      cmp("last_of_line", 64'(w.last_of_line), 64'(got.last_of_line));
      cmp("status",       64'(w.status),       64'(got.status));
    endfunction
  endclass

  logic                          clk_i;
  logic                          rst_ni        = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic [7:0]                    s_axis_tdata  = '0;
  logic                          m_axis_tready = 1'b0;
  logic                          psel          = 1'b0;
  logic                          penable       = 1'b0;
  logic                          pwrite        = 1'b0;
  logic [adfea_pkg::PADDR_W-1:0] paddr         = '0;
  logic [31:0]                   pwdata        = '0;
  logic                          s_axis_tready;
  logic                          m_axis_tvalid;
  logic [adfea_pkg::TDATA_W-1:0] m_axis_tdata;
  logic                          m_axis_tuser;
  logic                          m_axis_tlast;
  logic [31:0]                   prdata;
  logic                          pready;

  line_parse_scoreboard sb = new();
  int unsigned          send_idle_pct = 21;
  int unsigned          recv_idle_pct = 83;
  logic                 hold_req      = 1'b0;
  logic [7:0]           line_buf[$];

  adfea_line_parser i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // result side: check accepted words, random stalls, long hold-off on request
  initial begin
    adfea_pkg::res_t got;
    int unsigned     hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        got.is_feature   = m_axis_tuser;
        got.feat_id      = m_axis_tdata[63:0];
        got.grp_id       = m_axis_tdata[95:64];
        got.new_group    = m_axis_tdata[96];
        got.label        = m_axis_tdata[98:97];
        got.status       = m_axis_tdata[99];
        got.last_of_line = m_axis_tlast;
        sb.check_word(got);
      end
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // watchdog on cycles with no word moving on either side
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
    end
    $error("no word moved for %0d cycles, %0d words still due",
           WATCHDOG_LIMIT, sb.words_due.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endfunction

  function automatic void add_sep();
    int unsigned n;
    n = ($urandom_range(3) == 0) ? $urandom_range(2, 3) : 1;
    repeat (n) line_buf.push_back($urandom_range(1) ? adfea_pkg::CH_SPACE : adfea_pkg::CH_COLON);
  endfunction

  // skipped token: any bytes but separators and end of line
  function automatic void add_skip_token();
    logic [7:0] c;
    repeat ($urandom_range(1, 4)) begin
      do c = 8'($urandom_range(1, 255));
      while (c == adfea_pkg::CH_SPACE || c == adfea_pkg::CH_COLON);
      line_buf.push_back(c);
    end
  endfunction

  function automatic void add_label();
    case ($urandom_range(7))
      0: add_text("0");
      1: add_text("-2147483648");
      2: add_text("2147483647");
      3: add_text("+1");
      4: add_text($sformatf("-%0d", $urandom_range(1, 99999)));
      default: add_text($sformatf("%0d", int'($urandom_range(200)) - 100));
    endcase
  endfunction

  function automatic void add_feature();
    logic [63:0] f;
    case ($urandom_range(9))
      0: f = '1;
      1: f = '0;
      6, 7: f = {$urandom, $urandom};
      8: f = 64'hFFFF_FFFF_FFFF_FF00 | 64'($urandom_range(255));
      default: f = 64'($urandom_range(99));
    endcase
    case ($urandom_range(7))
      0: add_text("+");
      1: add_text("0");
      default: ;
    endcase
    add_text($sformatf("%0d", f));
  endfunction

  // small values repeat often so that group changes and repeats both occur
  function automatic void add_group();
    int g;
    if (sb.ignore_grp && $urandom_range(2) == 0) begin
      add_skip_token();
      return;
    end
    case ($urandom_range(9))
      0: g = 32'sh8000_0000;
      1: g = 32'sh7FFF_FFFF;
      2: g = int'($urandom);
      3: g = -int'($urandom_range(1, 1000));
      default: g = int'($urandom_range(3)) - 1;
    endcase
    if (g >= 0 && $urandom_range(3) == 0) add_text("+");
    add_text($sformatf("%0d", g));
  endfunction

  // damage a line: stray byte, inserted byte, overflowing number or pure noise
  function automatic void break_line();
    int unsigned pos;
    pos = $urandom_range(line_buf.size() - 1);
    case ($urandom_range(3))
      0: line_buf[pos] = 8'($urandom_range(1, 255));
      1: line_buf.insert(pos, 8'($urandom_range(1, 255)));
      2: begin
        add_sep();
        case ($urandom_range(2))
          0: add_text($sformatf("184467440737095516%0d", $urandom_range(16, 99)));
          1: add_text("5:2147483648");
          default: add_text("5:-2147483649");
        endcase
      end
      default: begin
        line_buf.delete();
        repeat ($urandom_range(1, 20)) line_buf.push_back(8'($urandom_range(255)));
      end
    endcase
  endfunction

  // mostly well-formed line with random content
  function automatic void build_random_line();
    line_buf.delete();
    if ($urandom_range(4) == 0) add_sep();
    add_skip_token();
    add_sep();
    add_skip_token();
    add_sep();
    add_label();
    repeat ($urandom_range(5)) begin
      add_sep();
      add_feature();
      add_sep();
      add_group();
    end
    case ($urandom_range(5))
      0: add_sep();
      1: begin
        add_sep();
        add_feature();
      end
      default: ;
    endcase
    if ($urandom_range(4) == 0) break_line();
  endfunction

  // offer one character, with random idle cycles ahead of it
  task automatic send_char(input logic [7:0] c);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.take_char(c);
  endtask

  task automatic send_buf();
    foreach (line_buf[i]) send_char(line_buf[i]);
    line_buf.delete();
  endtask

  task automatic send_text_line(input string s);
    add_text(s);
    send_buf();
    send_char(adfea_pkg::CH_EOL);
  endtask

  // wait until every due word is out and the pipeline is empty
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.words_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // register write, then read back
  task automatic write_ignore_group(input logic v);
    logic [31:0] rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= adfea_pkg::PADDR_W'(4 * adfea_pkg::REG_IGNORE_GROUP);
    pwdata  <= {31'd0, v};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    sb.ignore_grp = v;
    sb.reg_writes++;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd !== {31'd0, v}) begin
      $error("ignore_group readback: expected %0h, got %0h", {31'd0, v}, rd);
      sb.fails++;
    end
  endtask

  // stimulus
  initial begin
    int unsigned phase_start;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed lines: empty, short, labels, extremes, errors, separators
    send_text_line("");
    send_text_line("a b");
    send_text_line("a b +7");
    send_text_line("a b 0");
    send_text_line("a b -2147483648 1:2147483647 2:-2147483648 3:-2147483648");
    line_buf = '{8'h01, 8'hFF, adfea_pkg::CH_SPACE, 8'h80, 8'h7F, adfea_pkg::CH_SPACE};
    send_text_line("2147483647 18446744073709551615:0 0:0 0:5");
    send_text_line("::a  b:: -1 ::5:: +9  ");
    send_text_line("a b 1 5:3 9");
    send_text_line("a b 1 18446744073709551616:1");
    send_text_line("a b 1 5:2147483648");
    send_text_line("a b 1 5:-2147483649");
    send_text_line("a b 2147483648 5:1");
    send_text_line("a b 1 5x:2 7:7");
    send_text_line("a b 1 5:3- 6:6");
    send_text_line("a b 1 -5:3");
    send_text_line("a b 1 +:3");
    send_text_line("a b - 5:3");
    send_text_line("a b 1 0007:+007 8:/");
    send_text_line("a b 1 5;:1");

    // group ids forced to zero
    settle();
    write_ignore_group(1'b1);
    send_text_line("a b 1 5:zz- 6:-9 7:x");

    // register change in the middle of a group token
    settle();
    write_ignore_group(1'b0);
    add_text("a b 1 5:7");
    send_buf();
    settle();
    write_ignore_group(1'b1);
    send_text_line(" 6:8");
    settle();
    write_ignore_group(1'b0);

    // random lines under three idle patterns
    for (int k = 0; k < 3; k++) begin
      case (k)
        0: begin
          send_idle_pct = 21;
          recv_idle_pct = 83;
        end
        1: begin
          send_idle_pct = 83;
          recv_idle_pct = 21;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      if (k == 2) begin
        // receiver holds off while a feature-dense line keeps coming
        hold_req = 1'b1;
        add_text("p p 1");
        for (int j = 0; j < 30; j++) add_text($sformatf(" %0d:%0d", j, j % 3));
        send_buf();
        send_char(adfea_pkg::CH_EOL);
      end
      phase_start = sb.chars;
      while (sb.chars < phase_start + CHARS_PER_PHASE) begin
        build_random_line();
        send_buf();
        send_char(adfea_pkg::CH_EOL);
        if ($urandom_range(4) == 0) begin
          settle();
          write_ignore_group($urandom_range(1));
        end
      end
      settle();
      write_ignore_group($urandom_range(1));
    end

    settle();
    repeat (20) @(posedge clk_i);
    if (sb.words_due.size() != 0) begin
      $error("%0d result words never arrived", sb.words_due.size());
      sb.fails++;
    end
    $display("run covered %0d lines (%0d malformed) in %0d characters, %0d register writes",
             sb.lines, sb.bad_lines, sb.chars, sb.reg_writes);
    $display("words checked: %0d feature, %0d end of line", sb.feature_words, sb.eol_words);
    if (sb.fails == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
